FILE: design/rsakd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsakd_pkg;

  localparam int PRIME_BITS = 16;
  localparam int WORD_BITS  = 32;
  localparam int COEF_BITS  = WORD_BITS + 2;

  typedef logic [PRIME_BITS-1:0]       prime_t;
  typedef logic [WORD_BITS-1:0]        word_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    prime_t prime_p;
    prime_t prime_q;
    word_t  public_exp;
  } req_t;

  typedef struct packed {
    word_t modulus;
    word_t private_exp;
    word_t gcd_value;
  } rsp_t;

  typedef struct packed {
    logic  done;
    word_t remainder;
    coef_t product;
  } div_res_t;

endpackage
`default_nettype wire

FILE: design/rsakd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rsakd_req_if;
  logic              valid;
  logic              ready;
  rsakd_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsakd_rsp_if;
  logic              valid;
  logic              ready;
  rsakd_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/rsa_key_derivation.sv
// RSA private key derivation.
// A request on req carries two primes p and q and a public exponent e; the
// block answers with one response on rsp holding the modulus p*q, the
// private exponent d (Bezout coefficient of e modulo (p-1)*(q-1), folded
// positive) and gcd(e, (p-1)*(q-1)). A gcd other than one means d is no
// inverse.
// Both channels use valid/ready; a request is taken when both are high.
// One request is processed at a time and req.ready is high only while the
// block is idle. After acceptance, the products p*q and (p-1)*(q-1) are formed
// in turn on one shared 16x16 multiplier, then each Euclid step runs the
// bit-serial divider, which also accumulates quotient times coefficient, plus
// an update and a zero check. A new request is taken only once the previous
// one has finished and the block is back in idle.
// The response sits in an output register; a new request is accepted while it
// waits, and a finished result waits until the receiver has taken the
// previous one. Synchronous reset returns the block to idle and drops any
// pending response.
`timescale 1ns / 1ps
`default_nettype none
module rsa_key_derivation #(
  parameter int PRIME_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  rsakd_req_if.sink   req,
  rsakd_rsp_if.source rsp
);

  localparam logic [rsakd_pkg::PRIME_BITS-1:0] PMASK =
    (PRIME_WIDTH >= rsakd_pkg::PRIME_BITS) ? '1 :
    rsakd_pkg::PRIME_BITS'((1 << PRIME_WIDTH) - 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_N   = 3'd1;
  localparam logic [2:0] ST_MUL_PHI = 3'd2;
  localparam logic [2:0] ST_CHECK   = 3'd3;
  localparam logic [2:0] ST_DIV     = 3'd4;
  localparam logic [2:0] ST_UPDATE  = 3'd5;
  localparam logic [2:0] ST_FINISH  = 3'd6;

  logic [2:0]             state;
  logic [2:0]             state_next;
  rsakd_pkg::prime_t      p;
  rsakd_pkg::prime_t      q;
  rsakd_pkg::word_t       e;
  rsakd_pkg::word_t       n;
  rsakd_pkg::word_t       phi;
  rsakd_pkg::word_t       r_prev;
  rsakd_pkg::word_t       r_cur;
  rsakd_pkg::coef_t       t_prev;
  rsakd_pkg::coef_t       t_cur;
  rsakd_pkg::prime_t      mul_a;
  rsakd_pkg::prime_t      mul_b;
  rsakd_pkg::word_t       prod;
  rsakd_pkg::word_t       d_val;
  logic                   div_start;
  logic                   out_free;
  rsakd_pkg::div_res_t    div;

  rsakd_div_unit u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend   (r_prev),
    .divisor    (r_cur),
    .multiplier (t_cur),
    .res        (div)
  );

  assign req.ready = state == ST_IDLE;
  assign out_free  = !rsp.valid || rsp.ready;
  assign div_start = state == ST_CHECK && r_cur != '0;

  always_comb begin
    if (state == ST_MUL_PHI) begin
      mul_a = (p == '0) ? '0 : p - 1'b1;
      mul_b = (q == '0) ? '0 : q - 1'b1;
    end else begin
      mul_a = p;
      mul_b = q;
    end
    prod  = rsakd_pkg::WORD_BITS'(mul_a) * rsakd_pkg::WORD_BITS'(mul_b);
    d_val = t_prev[rsakd_pkg::WORD_BITS-1:0];
    if (t_prev < 0) begin
      d_val = phi + t_prev[rsakd_pkg::WORD_BITS-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_MUL_N;
        end
      end
      ST_MUL_N:   state_next = ST_MUL_PHI;
      ST_MUL_PHI: state_next = ST_CHECK;
      ST_CHECK:   state_next = (r_cur == '0) ? ST_FINISH : ST_DIV;
      ST_DIV: begin
        if (div.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE:  state_next = ST_CHECK;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        p <= req.data.prime_p & PMASK;
        q <= req.data.prime_q & PMASK;
        e <= req.data.public_exp;
      end
      ST_MUL_N: begin
        n <= prod;
      end
      ST_MUL_PHI: begin
        phi    <= prod;
        r_prev <= prod;
        r_cur  <= e;
        t_prev <= '0;
        t_cur  <= rsakd_pkg::coef_t'(1);
      end
      ST_UPDATE: begin
        r_prev <= r_cur;
        r_cur  <= div.remainder;
        t_prev <= t_cur;
        t_cur  <= t_prev - div.product;
      end
      ST_FINISH: begin
        if (out_free) begin
          rsp.data.modulus     <= n;
          rsp.data.private_exp <= d_val;
          rsp.data.gcd_value   <= r_prev;
        end
      end
      default: begin
      end
    endcase
  end

  // Each Euclid step must leave a remainder below the divisor it used.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> div.remainder < r_cur)
    else $error("remainder not below divisor");

  a_finish_zero_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> r_cur == '0)
    else $error("finished with nonzero remainder");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_FINISH)
    else $error("response raised outside finish");

  a_div_idle_outside: assert property (@(posedge clk) disable iff (rst)
    div.done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

endmodule
`default_nettype wire

FILE: design/rsakd_div_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. Each quotient bit also folds
// the multiplier into a running product, so the product equals quotient times
// multiplier when the division ends.
module rsakd_div_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire rsakd_pkg::word_t  dividend,
  input  wire rsakd_pkg::word_t  divisor,
  input  wire rsakd_pkg::coef_t  multiplier,
  output rsakd_pkg::div_res_t    res
);

  localparam int CNT_W = $clog2(rsakd_pkg::WORD_BITS);

  logic                              busy;
  logic [CNT_W-1:0]                  cnt;
  rsakd_pkg::word_t                  dvd;
  rsakd_pkg::word_t                  rem;
  rsakd_pkg::coef_t                  acc;
  logic [rsakd_pkg::WORD_BITS:0]     rem_sh;
  logic [rsakd_pkg::WORD_BITS:0]     diff;
  logic                              ge;
  logic                              last;
  rsakd_pkg::coef_t                  acc_next;

  always_comb begin
    rem_sh   = {rem, dvd[rsakd_pkg::WORD_BITS-1]};
    diff     = rem_sh - {1'b0, divisor};
    ge       = rem_sh >= {1'b0, divisor};
    acc_next = (acc <<< 1) + (ge ? multiplier : rsakd_pkg::coef_t'(0));
    last     = cnt == CNT_W'(rsakd_pkg::WORD_BITS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      acc <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= ge ? diff[rsakd_pkg::WORD_BITS-1:0] : rem_sh[rsakd_pkg::WORD_BITS-1:0];
      acc <= acc_next;
    end
  end

  assign res.done      = busy && last;
  assign res.remainder = rem;
  assign res.product   = acc;

endmodule
`default_nettype wire
